// File: rtl/mcwg_pkg.sv
// mcwg_pkg: widths and divider request/response types for the motor command gate
// used by mcwg_div and motor_command_watchdog_gate_top; no dependencies
package mcwg_pkg;

    localparam int AGE_W    = 16;
    localparam int LIM_W    = 10;
    localparam int FS_W     = 14;
    localparam int K_W      = 13;
    localparam int TO_W     = 16;
    localparam int PAY_W    = 16;
    localparam int RPM_W    = 13;
    localparam int DRV_W    = 11;
    localparam int MULB_W   = 14;
    localparam int PROD_W   = PAY_W + MULB_W;
    localparam int DIVD_W   = 22;
    localparam int DCNT_W   = $clog2(DIVD_W + 1);

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [FS_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: rtl/motor_command_watchdog_gate_top.sv
// motor_command_watchdog_gate_top: watchdog gate and drive scaling for two motor channels
// depends on mcwg_pkg and mcwg_div
//
// Tick, deadman, link-alive and unknown commands are handled in S_IDLE; a speed command
// also passes S_SPD (one shared multiplier, then truncation). A control period that ends
// in a drive runs per channel S_MUL (one multiply), S_DIVL (one load) and S_DIV (the
// shared bit-serial divider until it is done), for rpm*drive_limit/rpm_full_scale, then
// S_EMIT; other control periods go straight to S_EMIT. Input stall is high while an
// item is in work or a result waits for a free output register; one finished result
// may sit in the output register while the next beat is taken.
module motor_command_watchdog_gate_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            command,
    input  logic signed [15:0]    payload,
    input  logic                  link_online,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            action,
    output logic signed [10:0]    drive_ch1,
    output logic signed [10:0]    drive_ch2,
    output logic                  deadman_expired,
    output logic                  ch1_stale,
    output logic                  ch2_stale,
    output logic                  link_lost
);
    import mcwg_pkg::*;

    localparam logic [1:0] REG_LIMIT   = 2'd0;
    localparam logic [1:0] REG_FSCALE  = 2'd1;
    localparam logic [1:0] REG_K       = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_PERIOD  = 3'd1;
    localparam logic [2:0] CMD_DEADMAN = 3'd2;
    localparam logic [2:0] CMD_CH1     = 3'd3;
    localparam logic [2:0] CMD_CH2     = 3'd4;
    localparam logic [2:0] CMD_LINK    = 3'd5;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_DRIVE   = 3'd1;
    localparam logic [2:0] ACT_STOP    = 3'd2;
    localparam logic [2:0] ACT_INIT    = 3'd3;
    localparam logic [2:0] ACT_IDENT   = 3'd4;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SPD  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIVL = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]        state_reg, state_next;

    logic [LIM_W-1:0]  lim_reg, lim_next;
    logic [FS_W-1:0]   fs_reg, fs_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [TO_W-1:0]   to_reg, to_next;

    logic              dm_on_reg, dm_on_next;
    logic              live_reg, live_next;
    logic              init_reg, init_next;
    logic              idle_reg, idle_next;
    logic signed [RPM_W-1:0] rpm1_reg, rpm1_next;
    logic signed [RPM_W-1:0] rpm2_reg, rpm2_next;
    logic [AGE_W-1:0]  dm_age_reg, dm_age_next;
    logic [AGE_W-1:0]  c1_age_reg, c1_age_next;
    logic [AGE_W-1:0]  c2_age_reg, c2_age_next;
    logic [AGE_W-1:0]  ln_age_reg, ln_age_next;

    logic              ch_reg, ch_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [2:0]        act_reg, act_next;
    logic [3:0]        flg_reg, flg_next;
    logic signed [DRV_W-1:0] d1_reg, d1_next;
    logic signed [DRV_W-1:0] d2_reg, d2_next;

    logic              ov_reg, ov_next;
    logic [2:0]        oact_reg, oact_next;
    logic [3:0]        oflg_reg, oflg_next;
    logic signed [DRV_W-1:0] od1_reg, od1_next;
    logic signed [DRV_W-1:0] od2_reg, od2_next;

    logic signed [PAY_W-1:0]  mul_a;
    logic signed [MULB_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic              accept;
    logic              out_free;
    logic [PROD_W-1:0] prod_mag;
    logic signed [RPM_W-1:0] rpm_trunc;
    logic [DIVD_W-1:0] q_clamp;
    logic signed [DRV_W-1:0] drv_val;
    logic              f_dm, f_c1, f_c2, f_ln;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    mcwg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !ov_reg || !out_stall;

    // shared multiplier: speed conversion in idle, drive scaling otherwise
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            mul_a = payload;
            mul_b = $signed({1'b0, k_reg});
        end
        else
        begin
            mul_a = PAY_W'(ch_reg ? rpm2_reg : rpm1_reg);
            mul_b = $signed({{(MULB_W-LIM_W){1'b0}}, lim_reg});
        end
    end
    assign mul_p = mul_a * mul_b;

    // toward-zero truncation of the Q16 product
    assign rpm_trunc = prod_reg[PROD_W-2 -: RPM_W]
                     + RPM_W'(prod_reg[PROD_W-1] && (prod_reg[15:0] != '0));

    assign prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);

    always_comb
    begin
        if (div_rsp.quotient > DIVD_W'(lim_reg))
            q_clamp = DIVD_W'(lim_reg);
        else
            q_clamp = div_rsp.quotient;
        drv_val = prod_reg[PROD_W-1] ? -$signed(q_clamp[DRV_W-1:0])
                                     : $signed(q_clamp[DRV_W-1:0]);
    end

    assign f_dm = 32'(dm_age_reg) > 32'(to_reg);
    assign f_c1 = 32'(c1_age_reg) > 32'(to_reg);
    assign f_c2 = 32'(c2_age_reg) > 32'(to_reg);
    assign f_ln = 32'(ln_age_reg) > 32'(to_reg);

    assign div_req.start    = (state_reg == S_DIVL);
    assign div_req.dividend = prod_mag[DIVD_W-1:0];
    assign div_req.divisor  = fs_reg;

    always_comb
    begin
        state_next  = state_reg;
        lim_next    = lim_reg;
        fs_next     = fs_reg;
        k_next      = k_reg;
        to_next     = to_reg;
        dm_on_next  = dm_on_reg;
        live_next   = live_reg;
        init_next   = init_reg;
        idle_next   = idle_reg;
        rpm1_next   = rpm1_reg;
        rpm2_next   = rpm2_reg;
        dm_age_next = dm_age_reg;
        c1_age_next = c1_age_reg;
        c2_age_next = c2_age_reg;
        ln_age_next = ln_age_reg;
        ch_next     = ch_reg;
        prod_next   = prod_reg;
        act_next    = act_reg;
        flg_next    = flg_reg;
        d1_next     = d1_reg;
        d2_next     = d2_reg;
        ov_next     = ov_reg && out_stall;
        oact_next   = oact_reg;
        oflg_next   = oflg_reg;
        od1_next    = od1_reg;
        od2_next    = od2_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_LIMIT:   lim_next = cfg_data[LIM_W-1:0];
                REG_FSCALE:  fs_next  = cfg_data[FS_W-1:0];
                REG_K:       k_next   = cfg_data[K_W-1:0];
                REG_TIMEOUT: to_next  = cfg_data[TO_W-1:0];
                default:     lim_next = lim_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_TICK:
                        begin
                            dm_age_next = (&dm_age_reg) ? dm_age_reg : dm_age_reg + 1'b1;
                            c1_age_next = (&c1_age_reg) ? c1_age_reg : c1_age_reg + 1'b1;
                            c2_age_next = (&c2_age_reg) ? c2_age_reg : c2_age_reg + 1'b1;
                            ln_age_next = (&ln_age_reg) ? ln_age_reg : ln_age_reg + 1'b1;
                        end
                        CMD_DEADMAN:
                        begin
                            dm_on_next  = payload[0];
                            dm_age_next = '0;
                        end
                        CMD_CH1, CMD_CH2:
                        begin
                            ch_next    = (command == CMD_CH2);
                            live_next  = 1'b1;
                            prod_next  = mul_p;
                            state_next = S_SPD;
                            if (command == CMD_CH2)
                                c2_age_next = '0;
                            else
                                c1_age_next = '0;
                        end
                        CMD_LINK:
                            ln_age_next = '0;
                        CMD_PERIOD:
                        begin
                            act_next   = ACT_NONE;
                            flg_next   = '0;
                            d1_next    = '0;
                            d2_next    = '0;
                            state_next = S_EMIT;
                            if (!init_reg)
                            begin
                                if (link_online)
                                begin
                                    act_next  = ACT_INIT;
                                    init_next = 1'b1;
                                    idle_next = 1'b0;
                                end
                                else
                                    act_next = ACT_IDENT;
                            end
                            else if (idle_reg)
                            begin
                                if (32'(ln_age_reg) < 32'(to_reg))
                                    idle_next = 1'b0;
                            end
                            else if (dm_on_reg && live_reg)
                            begin
                                flg_next = {f_dm, f_c1, f_c2, f_ln};
                                if (f_dm)
                                    dm_on_next = 1'b0;
                                if (f_c1 || f_c2)
                                    live_next = 1'b0;
                                if (f_ln)
                                    init_next = 1'b0;
                                if (f_dm || f_c1 || f_c2 || f_ln)
                                begin
                                    rpm1_next = '0;
                                    rpm2_next = '0;
                                end
                                else
                                begin
                                    act_next   = ACT_DRIVE;
                                    ch_next    = 1'b0;
                                    state_next = S_MUL;
                                end
                            end
                            else
                            begin
                                act_next  = ACT_STOP;
                                idle_next = 1'b1;
                            end
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_SPD:
            begin
                if (ch_reg)
                    rpm2_next = rpm_trunc;
                else
                    rpm1_next = rpm_trunc;
                state_next = S_IDLE;
            end
            S_MUL:
            begin
                prod_next  = mul_p;
                state_next = S_DIVL;
            end
            S_DIVL:
                state_next = S_DIV;
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (ch_reg)
                    begin
                        d2_next    = drv_val;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        d1_next    = drv_val;
                        ch_next    = 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    oact_next  = act_reg;
                    oflg_next  = flg_reg;
                    od1_next   = d1_reg;
                    od2_next   = d2_reg;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            lim_reg    <= LIM_W'(700);
            fs_reg     <= FS_W'(2000);
            k_reg      <= K_W'(1280);
            to_reg     <= TO_W'(500);
            dm_on_reg  <= 1'b0;
            live_reg   <= 1'b0;
            init_reg   <= 1'b0;
            idle_reg   <= 1'b1;
            rpm1_reg   <= '0;
            rpm2_reg   <= '0;
            dm_age_reg <= '0;
            c1_age_reg <= '1;
            c2_age_reg <= '1;
            ln_age_reg <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            lim_reg    <= lim_next;
            fs_reg     <= fs_next;
            k_reg      <= k_next;
            to_reg     <= to_next;
            dm_on_reg  <= dm_on_next;
            live_reg   <= live_next;
            init_reg   <= init_next;
            idle_reg   <= idle_next;
            rpm1_reg   <= rpm1_next;
            rpm2_reg   <= rpm2_next;
            dm_age_reg <= dm_age_next;
            c1_age_reg <= c1_age_next;
            c2_age_reg <= c2_age_next;
            ln_age_reg <= ln_age_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        prod_reg <= prod_next;
        act_reg  <= act_next;
        flg_reg  <= flg_next;
        d1_reg   <= d1_next;
        d2_reg   <= d2_next;
        oact_reg <= oact_next;
        oflg_reg <= oflg_next;
        od1_reg  <= od1_next;
        od2_reg  <= od2_next;
    end

    assign out_valid       = ov_reg;
    assign action          = oact_reg;
    assign drive_ch1       = od1_reg;
    assign drive_ch2       = od2_reg;
    assign deadman_expired = oflg_reg[3];
    assign ch1_stale       = oflg_reg[2];
    assign ch2_stale       = oflg_reg[1];
    assign link_lost       = oflg_reg[0];

`ifndef ASSERT_OFF
    a_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && action != ACT_DRIVE) |-> (drive_ch1 == '0 && drive_ch2 == '0))
        else $error("nonzero drive without drive action");

    a_stale_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (deadman_expired || ch1_stale || ch2_stale || link_lost))
        |-> (action == ACT_NONE))
        else $error("stale source with an action other than none");

    a_tick_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && command == CMD_TICK && !out_valid) |=> !out_valid)
        else $error("tick beat produced a result");

    a_drive_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drive_ch1 <= $signed({1'b0, lim_reg})
                       && drive_ch1 >= -$signed({1'b0, lim_reg})
                       && drive_ch2 <= $signed({1'b0, lim_reg})
                       && drive_ch2 >= -$signed({1'b0, lim_reg})))
        else $error("drive beyond limit");
`endif

endmodule

// File: rtl/mcwg_div.sv
// mcwg_div: restoring unsigned divider, one quotient bit per cycle
// depends on mcwg_pkg
module mcwg_div (
    input  logic              clk,
    input  logic              rst_n,
    input  mcwg_pkg::div_req_t req,
    output mcwg_pkg::div_rsp_t rsp
);
    import mcwg_pkg::*;

    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [FS_W-1:0]   rem_reg, rem_next;
    logic [FS_W-1:0]   dvs_reg, dvs_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [FS_W:0]     trial;
    logic [FS_W:0]     diff;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = (req.divisor == '0) ? FS_W'(1) : req.divisor;
            cnt_next = DCNT_W'(DIVD_W);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[FS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[FS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DCNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: sim/mcwg_tb_pkg.sv
`timescale 1ns / 1ps
// mcwg_tb_pkg: command, action and register codes plus the result beat type for the gate bench
// depends on mcwg_pkg for the drive width
package mcwg_tb_pkg;

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_PERIOD     = 3'd1,
        CMD_DEADMAN    = 3'd2,
        CMD_CH1_SPEED  = 3'd3,
        CMD_CH2_SPEED  = 3'd4,
        CMD_LINK_ALIVE = 3'd5,
        CMD_RSVD6      = 3'd6,
        CMD_RSVD7      = 3'd7
    } gate_cmd_e;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_DRIVE     = 3'd1,
        ACT_STOP_IDLE = 3'd2,
        ACT_RUN_INIT  = 3'd3,
        ACT_IDENTITY  = 3'd4
    } gate_action_e;

    typedef enum logic [1:0] {
        REG_DRIVE_LIMIT    = 2'd0,
        REG_RPM_FULL_SCALE = 2'd1,
        REG_SPEED_TO_RPM   = 2'd2,
        REG_TIMEOUT_TICKS  = 2'd3
    } gate_reg_e;

    typedef struct packed {
        logic [2:0]                        action;
        logic signed [mcwg_pkg::DRV_W-1:0] drive_ch1;
        logic signed [mcwg_pkg::DRV_W-1:0] drive_ch2;
        logic                              deadman_expired;
        logic                              ch1_stale;
        logic                              ch2_stale;
        logic                              link_lost;
    } gate_result_t;

endpackage

// File: sim/motor_command_watchdog_gate_checker.sv
`timescale 1ns / 1ps
// motor_command_watchdog_gate_checker: watches config writes and both channels, predicts
// each control period result and compares it with the block's output beats
// depends on mcwg_pkg and mcwg_tb_pkg
module motor_command_watchdog_gate_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [15:0]                       cfg_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [2:0]                        command,
    input  logic signed [15:0]                payload,
    input  logic                              link_online,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [2:0]                        action,
    input  logic signed [mcwg_pkg::DRV_W-1:0] drive_ch1,
    input  logic signed [mcwg_pkg::DRV_W-1:0] drive_ch2,
    input  logic                              deadman_expired,
    input  logic                              ch1_stale,
    input  logic                              ch2_stale,
    input  logic                              link_lost,
    output int                                mismatch_count,
    output int                                pending_count
);
    import mcwg_pkg::*;
    import mcwg_tb_pkg::*;

    localparam logic [AGE_W-1:0] AGE_SAT = '1;

    logic [LIM_W-1:0]        lim_q;
    logic [FS_W-1:0]         fs_q;
    logic [K_W-1:0]          k_q;
    logic [TO_W-1:0]         to_q;
    logic                    dm_on;
    logic                    cmds_live;
    logic                    is_init;
    logic                    is_idle;
    logic signed [20:0]      rpm1;
    logic signed [20:0]      rpm2;
    logic [AGE_W-1:0]        dm_age;
    logic [AGE_W-1:0]        c1_age;
    logic [AGE_W-1:0]        c2_age;
    logic [AGE_W-1:0]        ln_age;
    gate_result_t            expected_results[$];
    gate_result_t            want_res;
    gate_result_t            got_res;
    gate_result_t            next_res;
    int                      errs = 0;

    function automatic logic [AGE_W-1:0] aged(input logic [AGE_W-1:0] a);
        return (a == AGE_SAT) ? a : a + 1'b1;
    endfunction

    function automatic logic signed [20:0] rpm_of(input logic signed [15:0] v);
        longint p;
        p = longint'(v) * longint'(k_q);
        return 21'(p / 65536);
    endfunction

    function automatic logic signed [DRV_W-1:0] drive_of(input logic signed [20:0] rpm);
        longint lim;
        longint div;
        longint d;
        lim = longint'(lim_q);
        div = (fs_q == 0) ? 1 : longint'(fs_q);
        d = longint'(rpm) * lim / div;
        if (d < -lim)
            d = -lim;
        else if (d > lim)
            d = lim;
        return DRV_W'(d);
    endfunction

    function automatic logic predict_gate_item(input gate_cmd_e cmd,
                                               input logic signed [15:0] pay,
                                               input logic online,
                                               output gate_result_t res);
        logic f_dm;
        logic f_c1;
        logic f_c2;
        logic f_ln;
        res = '0;
        case (cmd)
            CMD_TICK:
            begin
                dm_age = aged(dm_age);
                c1_age = aged(c1_age);
                c2_age = aged(c2_age);
                ln_age = aged(ln_age);
                return 1'b0;
            end
            CMD_DEADMAN:
            begin
                dm_on = pay[0];
                dm_age = '0;
                return 1'b0;
            end
            CMD_CH1_SPEED:
            begin
                c1_age = '0;
                cmds_live = 1'b1;
                rpm1 = rpm_of(pay);
                return 1'b0;
            end
            CMD_CH2_SPEED:
            begin
                c2_age = '0;
                cmds_live = 1'b1;
                rpm2 = rpm_of(pay);
                return 1'b0;
            end
            CMD_LINK_ALIVE:
            begin
                ln_age = '0;
                return 1'b0;
            end
            CMD_PERIOD:
            begin
            end
            default:
            begin
                return 1'b0;
            end
        endcase

        if (!is_init) begin
            if (online) begin
                res.action = ACT_RUN_INIT;
                is_init = 1'b1;
                is_idle = 1'b0;
            end else begin
                res.action = ACT_IDENTITY;
            end
        end else if (is_idle) begin
            if (ln_age < to_q)
                is_idle = 1'b0;
        end else if (dm_on && cmds_live) begin
            f_dm = dm_age > to_q;
            f_c1 = c1_age > to_q;
            f_c2 = c2_age > to_q;
            f_ln = ln_age > to_q;
            if (f_dm)
                dm_on = 1'b0;
            if (f_c1 || f_c2)
                cmds_live = 1'b0;
            if (f_ln)
                is_init = 1'b0;
            if (f_dm || f_c1 || f_c2 || f_ln) begin
                rpm1 = '0;
                rpm2 = '0;
            end else begin
                res.action = ACT_DRIVE;
                res.drive_ch1 = drive_of(rpm1);
                res.drive_ch2 = drive_of(rpm2);
            end
            res.deadman_expired = f_dm;
            res.ch1_stale = f_c1;
            res.ch2_stale = f_c2;
            res.link_lost = f_ln;
        end else begin
            res.action = ACT_STOP_IDLE;
            is_idle = 1'b1;
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            lim_q = 10'd700;
            fs_q = 14'd2000;
            k_q = 13'd1280;
            to_q = 16'd500;
            dm_on = 1'b0;
            cmds_live = 1'b0;
            is_init = 1'b0;
            is_idle = 1'b1;
            rpm1 = '0;
            rpm2 = '0;
            dm_age = '0;
            c1_age = AGE_SAT;
            c2_age = AGE_SAT;
            ln_age = '0;
            expected_results.delete();
            pending_count <= 0;
        end else begin
            if (cfg_we) begin
                case (gate_reg_e'(cfg_index))
                    REG_DRIVE_LIMIT:    lim_q = cfg_data[LIM_W-1:0];
                    REG_RPM_FULL_SCALE: fs_q = cfg_data[FS_W-1:0];
                    REG_SPEED_TO_RPM:   k_q = cfg_data[K_W-1:0];
                    REG_TIMEOUT_TICKS:  to_q = cfg_data[TO_W-1:0];
                    default:            ;
                endcase
            end

            if (out_valid && !out_stall) begin
                got_res = '{action, drive_ch1, drive_ch2, deadman_expired,
                            ch1_stale, ch2_stale, link_lost};
                if (expected_results.size() == 0) begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: unexpected result beat act=%0d d1=%0d d2=%0d flags=%b%b%b%b",
                                 $realtime, got_res.action, got_res.drive_ch1,
                                 got_res.drive_ch2, got_res.deadman_expired,
                                 got_res.ch1_stale, got_res.ch2_stale, got_res.link_lost);
                end else begin
                    want_res = expected_results.pop_front();
                    if (got_res.action !== want_res.action
                        || got_res.drive_ch1 !== want_res.drive_ch1
                        || got_res.drive_ch2 !== want_res.drive_ch2
                        || got_res.deadman_expired !== want_res.deadman_expired
                        || got_res.ch1_stale !== want_res.ch1_stale
                        || got_res.ch2_stale !== want_res.ch2_stale
                        || got_res.link_lost !== want_res.link_lost) begin
                        errs++;
                        if (errs <= 10)
                            $display("%0t: mismatch exp act=%0d d1=%0d d2=%0d flags=%b%b%b%b",
                                     $realtime, want_res.action, want_res.drive_ch1,
                                     want_res.drive_ch2, want_res.deadman_expired,
                                     want_res.ch1_stale, want_res.ch2_stale,
                                     want_res.link_lost,
                                     " got act=%0d d1=%0d d2=%0d flags=%b%b%b%b",
                                     got_res.action, got_res.drive_ch1,
                                     got_res.drive_ch2, got_res.deadman_expired,
                                     got_res.ch1_stale, got_res.ch2_stale,
                                     got_res.link_lost);
                    end
                end
            end

            if (in_valid && !in_stall) begin
                if (predict_gate_item(gate_cmd_e'(command), payload, link_online, next_res))
                    expected_results.push_back(next_res);
            end

            mismatch_count <= errs;
            pending_count <= expected_results.size();
        end
    end

endmodule

// File: sim/motor_command_watchdog_gate_top_test.sv
`timescale 1ns / 1ps
// motor_command_watchdog_gate_top_test: drives directed and random command beats and
// config settings into the gate, with a checker beside it and a no-progress watchdog
// depends on motor_command_watchdog_gate_top, motor_command_watchdog_gate_checker, mcwg_tb_pkg
module motor_command_watchdog_gate_top_test;
    import mcwg_tb_pkg::*;

    localparam int ITEM_TARGET   = 1850;
    localparam int PHASES        = 6;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_CYCLES  = 100;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         command = '0;
    logic signed [15:0] payload = '0;
    logic               link_online = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         action;
    logic signed [10:0] drive_ch1;
    logic signed [10:0] drive_ch2;
    logic               deadman_expired;
    logic               ch1_stale;
    logic               ch2_stale;
    logic               link_lost;
    int                 mismatch_count;
    int                 pending_count;
    int                 send_gap_pct = 17;
    int                 recv_stall_pct = 69;
    int                 items_sent = 0;
    int                 phase_goal;
    int                 quiet_cycles = 0;

    motor_command_watchdog_gate_top u_dut (.*);

    motor_command_watchdog_gate_checker u_checker (.*);

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [15:0] rand_payload();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input gate_cmd_e cmd, input logic [15:0] pay, input logic online);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        payload <= pay;
        link_online <= online;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (cmd != CMD_RSVD6 && cmd != CMD_RSVD7)
            items_sent++;
    endtask

    task automatic drain_and_settle(input int cycles);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (cycles)
            @(posedge clk);
    endtask

    task automatic write_settings(input int lim, input int fs, input int k, input int to);
        cfg_we <= 1'b1;
        cfg_index <= REG_DRIVE_LIMIT;
        cfg_data <= 16'(lim);
        @(posedge clk);
        cfg_index <= REG_RPM_FULL_SCALE;
        cfg_data <= 16'(fs);
        @(posedge clk);
        cfg_index <= REG_SPEED_TO_RPM;
        cfg_data <= 16'(k);
        @(posedge clk);
        cfg_index <= REG_TIMEOUT_TICKS;
        cfg_data <= 16'(to);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // up to eight random beats, mostly ticks and messages, then one control period
    task automatic run_period_block();
        int n;
        int r;
        logic [15:0] p;
        n = $urandom_range(0, 8);
        repeat (n) begin
            r = $urandom_range(0, 99);
            p = rand_payload();
            if (r < 8) begin
                send_item(gate_cmd_e'($urandom_range(0, 7)), p, 1'($urandom_range(0, 1)));
            end else if (r < 50) begin
                send_item(CMD_TICK, p, 1'($urandom_range(0, 1)));
            end else if (r < 63) begin
                p[0] = ($urandom_range(0, 4) != 0);
                send_item(CMD_DEADMAN, p, 1'($urandom_range(0, 1)));
            end else if (r < 76) begin
                send_item(CMD_CH1_SPEED, p, 1'($urandom_range(0, 1)));
            end else if (r < 89) begin
                send_item(CMD_CH2_SPEED, p, 1'($urandom_range(0, 1)));
            end else begin
                send_item(CMD_LINK_ALIVE, p, 1'($urandom_range(0, 1)));
            end
        end
        send_item(CMD_PERIOD, rand_payload(), $urandom_range(0, 9) != 0);
    endtask

    initial begin
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // uninitialised, ignored codes, init, stop, leave idle, drive
        send_item(CMD_PERIOD, 16'h0000, 1'b0);
        send_item(CMD_RSVD6, rand_payload(), 1'b1);
        send_item(CMD_RSVD7, rand_payload(), 1'b0);
        send_item(CMD_PERIOD, 16'hFFFF, 1'b1);
        send_item(CMD_PERIOD, 16'h0000, 1'b0);
        send_item(CMD_TICK, 16'h0000, 1'b0);
        send_item(CMD_PERIOD, 16'h0000, 1'b1);
        send_item(CMD_DEADMAN, 16'h0001, 1'b0);
        send_item(CMD_CH1_SPEED, 16'h7FFF, 1'b0);
        send_item(CMD_CH2_SPEED, 16'h8000, 1'b1);
        send_item(CMD_LINK_ALIVE, 16'h0000, 1'b0);
        send_item(CMD_PERIOD, 16'h0000, 1'b0);
        send_item(CMD_DEADMAN, 16'hFFFE, 1'b0);
        send_item(CMD_PERIOD, 16'h0000, 1'b0);
        send_item(CMD_PERIOD, 16'h0000, 1'b0);
        send_item(CMD_DEADMAN, 16'h0001, 1'b0);
        send_item(CMD_PERIOD, 16'h0000, 1'b0);

        // zero full scale, every source stale, then clamped drives both ways
        drain_and_settle(SETTLE_CYCLES);
        write_settings(1000, 0, 8191, 1);
        send_item(CMD_TICK, 16'h0000, 1'b0);
        send_item(CMD_TICK, 16'h0000, 1'b0);
        send_item(CMD_PERIOD, 16'h0000, 1'b0);
        send_item(CMD_PERIOD, 16'h0000, 1'b1);
        send_item(CMD_CH1_SPEED, 16'h7FFF, 1'b0);
        send_item(CMD_CH2_SPEED, 16'h8000, 1'b0);
        send_item(CMD_DEADMAN, 16'h0001, 1'b0);
        send_item(CMD_LINK_ALIVE, 16'h0000, 1'b0);
        send_item(CMD_PERIOD, 16'h0000, 1'b0);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_and_settle(SETTLE_CYCLES);
            case (phase / 2)
                0:
                begin
                    send_gap_pct <= 17;
                    recv_stall_pct <= 69;
                end
                1:
                begin
                    send_gap_pct <= 69;
                    recv_stall_pct <= 17;
                end
                default:
                begin
                    send_gap_pct <= 0;
                    recv_stall_pct <= 0;
                end
            endcase
            case (phase)
                0: write_settings(1000, 1, 8191, 4);
                1: write_settings(0, 10000, 0, 1);
                2: write_settings(512, 0, 300, 8);
                3: write_settings($urandom_range(0, 1000), $urandom_range(1, 10000),
                                  $urandom_range(0, 8191), $urandom_range(2, 12));
                4: write_settings(1000, 10000, 8191, 65535);
                default: write_settings($urandom_range(1, 1000), $urandom_range(1, 10000),
                                        $urandom_range(0, 8191), $urandom_range(1, 30));
            endcase
            phase_goal = items_sent + (ITEM_TARGET - items_sent) / (PHASES - phase);
            while (items_sent < phase_goal)
                run_period_block();
        end

        drain_and_settle(DRAIN_CYCLES);
        if (mismatch_count == 0 && pending_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
